/* design/evad_pkg.sv */
`timescale 1ns / 1ps

package evad_pkg;

   // Register file
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_RMS  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_PEAK = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_RMS    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONFIRM    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HANGOVER   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACT_LIMIT  = 3'd5;

   // Result codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_START = 2'd1;
   localparam logic [1:0] EV_END   = 2'd2;

   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_SILENCE = 2'd1;
   localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

   typedef struct packed {
      logic [1:0] vad_event;
      logic [1:0] end_cause;
   } rsp_type;

endpackage

/* design/energy_vad_hangover_fsm.sv */
`timescale 1ns / 1ps

// Energy voice-activity detector with hangover.
//
// Request channel (req_*): one beat per audio frame, carrying its RMS and peak
// level. Response channel (rsp_*): exactly one beat per request beat, in order,
// with the event (none / voice start / voice end) and, on voice end, its cause
// (silence or timeout). Both channels move a beat at a clock edge where valid
// is high and stall is low.
//
// A frame's response is registered in the output or, while one waits, the skid
// register. Throughput: one frame per cycle while req_stall is low; the state
// update (a handful of compares, saturating increments) ends in the accept cycle.
//
// Stall: a two-entry output queue (output register plus skid register) sits in
// front of rsp_*. A new frame is still taken while one response waits; only
// when both entries are full is req_stall raised, and it comes from a flop.
//
// Reset (synchronous, active high): detector goes idle with all run counters
// cleared, the output queue empties and the six csr registers return to their
// defaults. csr writes are registered and are meant for idle periods.
module energy_vad_hangover_fsm #(
   parameter int LEVEL_WIDTH = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // config write port
   input  logic                                  csr_we,
   input  logic [evad_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [evad_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [LEVEL_WIDTH-1:0]                req_frame_rms,
   input  logic [LEVEL_WIDTH-1:0]                req_frame_peak,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_vad_event,
   output logic [1:0]                            rsp_end_cause
);

   // Detector phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SPEECH = 2'd1;
   localparam logic [1:0] PH_HANG   = 2'd2;
   localparam logic [1:0] PH_UNUSED = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   logic [LEVEL_WIDTH-1:0] rms_gate_ff, peak_gate_ff, end_rms_ff;
   logic [COUNT_WIDTH-1:0] confirm_ff, hangover_ff, act_limit_ff;
   logic [63:0]            wdata_wide;

   // zero-extend so any parameter width can take its low bits
   assign wdata_wide = 64'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         rms_gate_ff   <= LEVEL_WIDTH'(800);
         peak_gate_ff  <= LEVEL_WIDTH'(3000);
         end_rms_ff    <= LEVEL_WIDTH'(500);
         confirm_ff    <= COUNT_WIDTH'(3);
         hangover_ff   <= COUNT_WIDTH'(50);
         act_limit_ff  <= COUNT_WIDTH'(1500);
      end else if (csr_we) begin
         unique case (csr_index)
            evad_pkg::CSR_START_RMS:  rms_gate_ff   <= wdata_wide[LEVEL_WIDTH-1:0];
            evad_pkg::CSR_START_PEAK: peak_gate_ff  <= wdata_wide[LEVEL_WIDTH-1:0];
            evad_pkg::CSR_END_RMS:    end_rms_ff    <= wdata_wide[LEVEL_WIDTH-1:0];
            evad_pkg::CSR_CONFIRM:    confirm_ff    <= wdata_wide[COUNT_WIDTH-1:0];
            evad_pkg::CSR_HANGOVER:   hangover_ff   <= wdata_wide[COUNT_WIDTH-1:0];
            evad_pkg::CSR_ACT_LIMIT:  act_limit_ff  <= wdata_wide[COUNT_WIDTH-1:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Detector state and next-state logic
   // ---------------------------------------------------------------
   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] loud_run_ff, loud_run_in;
   logic [COUNT_WIDTH-1:0] quiet_run_ff, quiet_run_in;
   logic [COUNT_WIDTH-1:0] active_ff, active_in;
   evad_pkg::rsp_type      result;

   logic                   accept;
   logic                   is_loud, is_quiet;
   logic [COUNT_WIDTH-1:0] loud_inc, quiet_inc, active_inc;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_WIDTH'(1);
   endfunction

   assign accept     = req_valid && !req_stall;
   assign is_loud    = (req_frame_rms >= rms_gate_ff) && (req_frame_peak >= peak_gate_ff);
   assign is_quiet   = (req_frame_rms <= end_rms_ff);
   assign loud_inc   = sat_inc(loud_run_ff);
   assign quiet_inc  = sat_inc(quiet_run_ff);
   assign active_inc = sat_inc(active_ff);

   always_comb begin
      phase_in     = phase_ff;
      loud_run_in  = loud_run_ff;
      quiet_run_in = quiet_run_ff;
      active_in    = active_ff;
      result       = '{vad_event: evad_pkg::EV_NONE, end_cause: evad_pkg::CAUSE_NONE};

      unique case (phase_ff)
         PH_IDLE: begin
            active_in    = '0;
            quiet_run_in = '0;
            if (is_loud) begin
               loud_run_in = loud_inc;
               if (loud_inc >= confirm_ff) begin
                  phase_in         = PH_SPEECH;
                  loud_run_in      = '0;
                  result.vad_event = evad_pkg::EV_START;
               end
            end else begin
               loud_run_in = '0;
            end
         end
         PH_SPEECH, PH_HANG: begin
            active_in = active_inc;
            // timeout is checked before the frame level
            if (active_inc >= act_limit_ff) begin
               phase_in         = PH_IDLE;
               loud_run_in      = '0;
               quiet_run_in     = '0;
               active_in        = '0;
               result.vad_event = evad_pkg::EV_END;
               result.end_cause = evad_pkg::CAUSE_TIMEOUT;
            end else if (is_quiet) begin
               quiet_run_in = quiet_inc;
               if (phase_ff == PH_SPEECH) begin
                  // first quiet frame only opens hangover
                  phase_in = PH_HANG;
               end else if (quiet_inc >= hangover_ff) begin
                  phase_in         = PH_IDLE;
                  loud_run_in      = '0;
                  quiet_run_in     = '0;
                  active_in        = '0;
                  result.vad_event = evad_pkg::EV_END;
                  result.end_cause = evad_pkg::CAUSE_SILENCE;
               end
            end else begin
               // not quiet: back to speech silently
               phase_in     = PH_SPEECH;
               quiet_run_in = '0;
            end
         end
         default: begin
            // unused code: recover to idle, no event
            phase_in     = PH_IDLE;
            loud_run_in  = '0;
            quiet_run_in = '0;
            active_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         loud_run_ff  <= '0;
         quiet_run_ff <= '0;
         active_ff    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         loud_run_ff  <= loud_run_in;
         quiet_run_ff <= quiet_run_in;
         active_ff    <= active_in;
      end
   end

   // ---------------------------------------------------------------
   // Output queue: output register plus skid register
   // ---------------------------------------------------------------
   logic              out_valid_ff, skid_valid_ff;
   evad_pkg::rsp_type out_ff, skid_ff;
   logic              pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;  // no accept here, stall was high
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (accept && (pop || !out_valid_ff)) begin
         out_ff <= result;
      end
      if (accept && out_valid_ff && !pop) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_vad_event = out_ff.vad_event;
   assign rsp_end_cause = out_ff.end_cause;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_cause_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_cause == evad_pkg::CAUSE_NONE) ||
                    (rsp_vad_event == evad_pkg::EV_END))
      else $error("end cause reported without voice end");

   a_no_unused_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_UNUSED)
      else $error("detector phase reached unused code");

   a_start_enters_speech: assert property (@(posedge clock) disable iff (reset)
      accept && (result.vad_event == evad_pkg::EV_START) |=> phase_ff == PH_SPEECH)
      else $error("voice start without entering speech");

   a_end_clears_counts: assert property (@(posedge clock) disable iff (reset)
      accept && (result.vad_event == evad_pkg::EV_END) |=>
         (phase_ff == PH_IDLE) && (active_ff == '0) && (quiet_run_ff == '0))
      else $error("voice end did not return detector to idle");

endmodule

/* tb/sv/energy_vad_hangover_fsm_test.sv */
`timescale 1ns / 1ps

typedef enum logic [1:0] {
   PH_IDLE   = 2'd0,
   PH_SPEECH = 2'd1,
   PH_HANG   = 2'd2
} vad_phase_type;

// Tracks the detector state and queues the expected response per frame beat.
class vad_segment_checker;
   logic [15:0]       rms_gate, peak_gate, end_rms;
   logic [15:0]       confirm_len, hang_len, seg_limit;
   vad_phase_type     phase;
   logic [15:0]       loud_run, quiet_run, seg_frames;
   evad_pkg::rsp_type awaited[$];
   int                mismatches;
   int                starts, silence_ends, timeout_ends, settings;

   function new();
      rms_gate    = 16'd800;
      peak_gate   = 16'd3000;
      end_rms     = 16'd500;
      confirm_len = 16'd3;
      hang_len    = 16'd50;
      seg_limit   = 16'd1500;
      go_idle();
   endfunction

   function void go_idle();
      phase      = PH_IDLE;
      loud_run   = '0;
      quiet_run  = '0;
      seg_frames = '0;
   endfunction

   // counters stick at all-ones
   function logic [15:0] bump(logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   function void write_reg(logic [evad_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [15:0] v);
      case (idx)
         evad_pkg::CSR_START_RMS:  rms_gate    = v;
         evad_pkg::CSR_START_PEAK: peak_gate   = v;
         evad_pkg::CSR_END_RMS:    end_rms     = v;
         evad_pkg::CSR_CONFIRM:    confirm_len = v;
         evad_pkg::CSR_HANGOVER:   hang_len    = v;
         evad_pkg::CSR_ACT_LIMIT:  seg_limit   = v;
         default: ;
      endcase
   endfunction

   function void note_frame(logic [15:0] rms, logic [15:0] peak);
      evad_pkg::rsp_type r;
      logic              quiet;
      r.vad_event = evad_pkg::EV_NONE;
      r.end_cause = evad_pkg::CAUSE_NONE;
      quiet = (rms <= end_rms);
      case (phase)
         PH_IDLE: begin
            seg_frames = '0;
            quiet_run  = '0;
            if (rms >= rms_gate && peak >= peak_gate) begin
               loud_run = bump(loud_run);
               if (loud_run >= confirm_len) begin
                  phase       = PH_SPEECH;
                  loud_run    = '0;
                  r.vad_event = evad_pkg::EV_START;
                  starts++;
               end
            end else begin
               loud_run = '0;
            end
         end
         PH_SPEECH, PH_HANG: begin
            // segment length is checked before the frame level
            seg_frames = bump(seg_frames);
            if (seg_frames >= seg_limit) begin
               go_idle();
               r.vad_event = evad_pkg::EV_END;
               r.end_cause = evad_pkg::CAUSE_TIMEOUT;
               timeout_ends++;
            end else if (quiet) begin
               quiet_run = bump(quiet_run);
               // the hangover length only counts once already in hangover
               if (phase == PH_HANG && quiet_run >= hang_len) begin
                  go_idle();
                  r.vad_event = evad_pkg::EV_END;
                  r.end_cause = evad_pkg::CAUSE_SILENCE;
                  silence_ends++;
               end else begin
                  phase = PH_HANG;
               end
            end else begin
               phase     = PH_SPEECH;
               quiet_run = '0;
            end
         end
         default: go_idle();
      endcase
      awaited.push_back(r);
   endfunction

   function void check_response(logic [1:0] ev, logic [1:0] cause);
      evad_pkg::rsp_type want;
      if (awaited.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: response beat with none pending: event %0d cause %0d",
                     $realtime, ev, cause);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      if (ev !== want.vad_event || cause !== want.end_cause) begin
         if (mismatches < 10)
            $display("%0t: mismatch: event exp %0d got %0d, cause exp %0d got %0d",
                     $realtime, want.vad_event, ev, want.end_cause, cause);
         mismatches++;
      end
   endfunction
endclass

module energy_vad_hangover_fsm_test;

   logic                                 clock          = 1'b0;
   logic                                 reset          = 1'b1;
   logic                                 csr_we         = 1'b0;
   logic [evad_pkg::CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [evad_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata      = '0;
   logic                                 req_valid      = 1'b0;
   logic                                 req_stall;
   logic [15:0]                          req_frame_rms  = '0;
   logic [15:0]                          req_frame_peak = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall      = 1'b0;
   logic [1:0]                           rsp_vad_event;
   logic [1:0]                           rsp_end_cause;

   vad_segment_checker tracker;

   // chance per cycle (percent) that each side holds off
   int send_gap_pct = 34;
   int recv_gap_pct = 48;
   int frames_sent  = 0;

   always #2 clock = ~clock;

   energy_vad_hangover_fsm u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_rms  (req_frame_rms),
      .req_frame_peak (req_frame_peak),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_vad_event  (rsp_vad_event),
      .rsp_end_cause  (rsp_end_cause)
   );

   // Receiver back-pressure: redrawn every falling edge, so stalls land on
   // any cycle of the output queue, including while it is full.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_gap_pct);
   end

   // Response beats are taken at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && tracker != null)
         tracker.check_response(rsp_vad_event, rsp_end_cause);
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #400000;
      $display("timeout: %0d responses still pending", tracker.awaited.size());
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [15:0] pick(logic [15:0] lo, logic [15:0] hi);
      return 16'($urandom_range(hi, lo));
   endfunction

   // One frame beat. Drive at the falling edge, optionally after random idle
   // cycles; hold payload steady until the rising edge that takes it.
   task automatic send_frame(input logic [15:0] rms, input logic [15:0] peak);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_rms  <= rms;
      req_frame_peak <= peak;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_frame(rms, peak);
      frames_sent++;
   endtask

   // Frames shaped against the current thresholds.
   task automatic send_loud();
      logic [15:0] r, p;
      r = ($urandom_range(0, 3) == 0) ? tracker.rms_gate  : pick(tracker.rms_gate, 16'hFFFF);
      p = ($urandom_range(0, 3) == 0) ? tracker.peak_gate : pick(tracker.peak_gate, 16'hFFFF);
      send_frame(r, p);
   endtask

   task automatic send_quiet();
      logic [15:0] r;
      r = ($urandom_range(0, 3) == 0) ? tracker.end_rms : pick(16'd0, tracker.end_rms);
      send_frame(r, 16'($urandom));
   endtask

   // not quiet; when every level is quiet this degrades to a quiet frame
   task automatic send_lively();
      logic [15:0] r;
      if (tracker.end_rms == 16'hFFFF)
         r = 16'hFFFF;
      else
         r = pick(tracker.end_rms + 16'd1, 16'hFFFF);
      send_frame(r, 16'($urandom));
   endtask

   task automatic send_noise();
      send_frame(16'($urandom), 16'($urandom));
   endtask

   // Loud run to confirm a start, a mixed body, then a quiet tail long
   // enough to end the segment most of the time; some runs are cut short.
   task automatic utterance();
      int n_loud, n_body, n_tail;
      n_loud = (tracker.confirm_len > 16'd24) ? 24
               : int'(tracker.confirm_len) + $urandom_range(0, 1);
      for (int i = 0; i < n_loud; i++) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_loud();
      end
      n_body = $urandom_range(0, 12);
      for (int i = 0; i < n_body; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_lively();
            6, 7, 8:          send_quiet();
            default:          send_noise();
         endcase
      end
      n_tail = (tracker.hang_len > 16'd58) ? 60 : int'(tracker.hang_len) + $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) n_tail = $urandom_range(1, n_tail);
      for (int i = 0; i < n_tail; i++) send_quiet();
   endtask

   // Let every pending response drain; each frame yields exactly one, so
   // the block is idle once the queue is empty (plus a small margin).
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [evad_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      tracker.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_regs(input logic [15:0] s_rms, input logic [15:0] s_peak,
                               input logic [15:0] e_rms, input logic [15:0] confirm,
                               input logic [15:0] hang,  input logic [15:0] limit);
      write_reg(evad_pkg::CSR_START_RMS,  s_rms);
      write_reg(evad_pkg::CSR_START_PEAK, s_peak);
      write_reg(evad_pkg::CSR_END_RMS,    e_rms);
      write_reg(evad_pkg::CSR_CONFIRM,    confirm);
      write_reg(evad_pkg::CSR_HANGOVER,   hang);
      write_reg(evad_pkg::CSR_ACT_LIMIT,  limit);
      tracker.settings++;
   endtask

   initial begin
      int base;
      tracker = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed, reset thresholds (800 / 3000 / 500, confirm 3) ---
      send_frame(16'd0, 16'd0);            // silence, floor values
      send_frame(16'd800, 16'd2999);       // peak one short: run stays clear
      send_frame(16'd800, 16'd3000);       // exactly at both start levels
      send_frame(16'hFFFF, 16'hFFFF);
      send_frame(16'd799, 16'hFFFF);       // rms one short breaks the run
      send_frame(16'd800, 16'd3000);
      send_frame(16'd800, 16'd3000);
      send_frame(16'd800, 16'd3000);       // third in a row: voice start
      send_frame(16'd500, 16'd0);          // at end level: into hangover
      send_frame(16'd501, 16'd0);          // above end level: back to speech silently
      send_frame(16'd0, 16'd0);            // hangover again

      // --- zero confirm and zero hangover, short segment limit ---
      settle();
      program_regs(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd4);
      send_frame(16'd0, 16'hFFFE);         // not loud: no start even with confirm 0
      send_frame(16'd0, 16'hFFFF);         // first loud frame starts
      send_frame(16'd0, 16'd0);            // first quiet in speech: no end test yet
      send_frame(16'd0, 16'd0);            // in hangover, zero length: silence end
      send_frame(16'hFFFF, 16'hFFFF);      // start
      send_frame(16'd1, 16'd0);
      send_frame(16'd1, 16'd0);
      send_frame(16'd1, 16'd0);
      send_frame(16'd1, 16'd0);            // fourth frame hits the limit: timeout

      // --- zero segment limit: timeout on the first frame after start ---
      settle();
      write_reg(evad_pkg::CSR_ACT_LIMIT, 16'd0);
      send_frame(16'hFFFF, 16'hFFFF);
      send_frame(16'd0, 16'd0);            // quiet, but timeout wins

      // --- random part: nine register settings, three idling profiles ---
      for (int s = 0; s < 9; s++) begin
         settle();
         if (s == 3) begin
            send_gap_pct = 48;
            recv_gap_pct = 34;
         end else if (s == 6) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         case (s)
            1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
            2: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            4: program_regs(pick(16'd200, 16'd2000), pick(16'd500, 16'd8000),
                            pick(16'd0, 16'd600), 16'd2, pick(16'd0, 16'd5), 16'd1);
            5: program_regs(pick(16'd0, 16'd2000), pick(16'd0, 16'd8000),
                            pick(16'd0, 16'd600), 16'hFFFF, pick(16'd0, 16'd5),
                            pick(16'd1, 16'd40));
            7: program_regs(16'd800, 16'd3000, 16'd500, 16'd3, 16'd50, 16'd1500);
            default:
               program_regs(pick(16'd200, 16'd2000), pick(16'd500, 16'd8000),
                            pick(16'd0, 16'd1500), pick(16'd0, 16'd4),
                            pick(16'd0, 16'd6), pick(16'd1, 16'd40));
         endcase
         base = frames_sent;
         while (frames_sent - base < 203) begin
            if ($urandom_range(0, 6) != 0) utterance();
            else repeat ($urandom_range(1, 4)) send_noise();
         end
      end

      settle();
      repeat (8) @(posedge clock);

      $display("%0d frames under %0d register settings: %0d voice starts,",
               frames_sent, tracker.settings, tracker.starts);
      $display("%0d silence ends, %0d timeout ends, %0d mismatches, %0d missing",
               tracker.silence_ends, tracker.timeout_ends, tracker.mismatches,
               tracker.awaited.size());
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
